// ===== hdl/ibw_pkg.sv =====
// ----------------------------------------------------------------------------
// ibw_pkg
// shared widths and limits of the inverse bilinear weights core
// ----------------------------------------------------------------------------
package ibw_pkg;

	// port widths
	localparam int PT_W  = 14;
	localparam int CRD_W = 20;
	localparam int OUT_W = 21;

	// output saturation limits
	localparam int OUT_MAX = 1048575;
	localparam int OUT_MIN = -1048576;

	// control flags that travel with each item
	typedef struct packed {
		logic vld;
		logic degen;
		logic lin;
		logic neg;
	} ibw_flags_t;

endpackage

// ===== hdl/ibw_div.sv =====
// ----------------------------------------------------------------------------
// ibw_div
// pipelined signed divider, one quotient bit per stage, rounded and clamped
// ----------------------------------------------------------------------------
module ibw_div #(
	parameter int NIW = 50,
	parameter int DIW = 50,
	parameter int QW  = 22,
	parameter int FB  = 16
) (
	input  logic                  clk,
	input  logic signed [NIW-1:0] n,
	input  logic signed [DIW-1:0] d,
	output logic signed [QW+1:0]  q
);

	localparam int NMW = NIW + FB;
	localparam int HW  = NMW - QW;
	localparam int CW  = (HW > DIW) ? HW : DIW;

	logic [NIW-1:0] n_mag;
	logic [DIW-1:0] d_mag;
	logic [NMW-1:0] nm;
	logic [HW-1:0]  nm_hi;
	logic           ovf;

	logic           neg_s [QW+1];
	logic           nz_s  [QW+1];
	logic           ovf_s [QW+1];
	logic [DIW-1:0] dm_s  [QW+1];
	logic [DIW-1:0] rem_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic [QW-1:0]  low_s [QW+1];

	logic           rnd;
	logic [QW:0]    mag;

	assign n_mag = n[NIW-1] ? NIW'(-n) : NIW'(n);
	assign d_mag = d[DIW-1] ? DIW'(-d) : DIW'(d);
	assign nm    = {n_mag, {FB{1'b0}}};
	assign nm_hi = nm[NMW-1:QW];
	// quotient would not fit in QW bits, also covers a zero divisor
	assign ovf   = CW'(nm_hi) >= CW'(d_mag);

	always_ff @(posedge clk) begin
		neg_s[0] <= n[NIW-1] ^ d[DIW-1];
		nz_s[0]  <= (n != '0);
		ovf_s[0] <= ovf;
		dm_s[0]  <= d_mag;
		rem_s[0] <= DIW'(nm_hi);
		quo_s[0] <= '0;
		low_s[0] <= nm[QW-1:0];
	end

	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic [DIW:0] rs;
		logic [DIW:0] dx;
		logic         ge;

		assign rs = {rem_s[i-1], low_s[i-1][QW-1]};
		assign dx = {1'b0, dm_s[i-1]};
		assign ge = rs >= dx;

		always_ff @(posedge clk) begin
			neg_s[i] <= neg_s[i-1];
			nz_s[i]  <= nz_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
			dm_s[i]  <= dm_s[i-1];
			rem_s[i] <= ge ? DIW'(rs - dx) : DIW'(rs);
			quo_s[i] <= {quo_s[i-1][QW-2:0], ge};
			low_s[i] <= low_s[i-1] << 1;
		end
	end

	// round half away from zero on the magnitude
	assign rnd = {rem_s[QW], 1'b0} >= {1'b0, dm_s[QW]};
	assign mag = ovf_s[QW] ? {1'b1, {QW{1'b0}}} : ({1'b0, quo_s[QW]} + (QW+1)'(rnd));

	always_ff @(posedge clk) begin
		if (!nz_s[QW]) begin
			q <= '0;
		end else if (neg_s[QW]) begin
			q <= -$signed({1'b0, mag});
		end else begin
			q <= $signed({1'b0, mag});
		end
	end

endmodule

// ===== hdl/inverse_bilinear_weights_core.sv =====
// ----------------------------------------------------------------------------
// inverse_bilinear_weights_core
// inverse bilinear coordinates (u, v) of a pixel point inside a quad cell
// throughput: one item per cycle, busy stays low, no stall anywhere
// the sqrt pipeline (one root bit per stage) and the dividers set the depth
// reset: arst_n clears the flag registers and done, datapath registers are not reset
// ----------------------------------------------------------------------------
module inverse_bilinear_weights_core #(
	parameter int COORD_FRAC_BITS  = 4,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic        [ibw_pkg::PT_W-1:0]    point_x,
	input  logic        [ibw_pkg::PT_W-1:0]    point_y,
	input  logic signed [ibw_pkg::CRD_W-1:0]   top_left_x,
	input  logic signed [ibw_pkg::CRD_W-1:0]   top_left_y,
	input  logic signed [ibw_pkg::CRD_W-1:0]   top_right_x,
	input  logic signed [ibw_pkg::CRD_W-1:0]   top_right_y,
	input  logic signed [ibw_pkg::CRD_W-1:0]   bottom_right_x,
	input  logic signed [ibw_pkg::CRD_W-1:0]   bottom_right_y,
	input  logic signed [ibw_pkg::CRD_W-1:0]   bottom_left_x,
	input  logic signed [ibw_pkg::CRD_W-1:0]   bottom_left_y,
	output logic                               done,
	output logic signed [ibw_pkg::OUT_W-1:0]   weight_u,
	output logic signed [ibw_pkg::OUT_W-1:0]   weight_v,
	output logic                               solution_valid
);

	// vector width: g needs 22 bits, h grows with the point scaling
	localparam int VW  = (16 + COORD_FRAC_BITS > 22) ? 16 + COORD_FRAC_BITS : 22;
	localparam int KW  = 2 * VW + 2;        // k2, k1, k0
	localparam int LK  = KW / 2;            // low slice for the square products
	localparam int DW  = 2 * KW + 3;        // discriminant
	localparam int SW  = DW / 2;            // root bits
	localparam int XW  = 2 * SW;
	localparam int RW  = SW + 2;            // sqrt remainder
	localparam int NW  = SW + 3;            // a, b1, b2
	localparam int LN  = NW / 2;
	localparam int PW  = VW + NW + 2;       // u numerator and denominator
	localparam int QW  = (WEIGHT_FRAC_BITS + 2 > 22) ? WEIGHT_FRAC_BITS + 2 : 22;
	localparam int LIN_LIM = ((1 << (2 * COORD_FRAC_BITS)) + 999) / 1000;
	localparam int LATENCY = SW + QW + 14;
	localparam logic signed [QW+1:0] ONE_Q = (QW+2)'(1 << WEIGHT_FRAC_BITS);

	typedef struct packed {
		logic signed [KW-1:0] k0;
		logic signed [KW-1:0] k1;
		logic signed [KW-1:0] k2;
		logic signed [VW-1:0] hx;
		logic signed [VW-1:0] ex;
		logic signed [VW-1:0] fx;
		logic signed [VW-1:0] gx;
	} sb_t;

	function automatic logic signed [ibw_pkg::OUT_W-1:0] sat_w(input logic signed [QW+1:0] x);
		logic signed [ibw_pkg::OUT_W-1:0] r;
		if (x > ibw_pkg::OUT_MAX) begin
			r = ibw_pkg::OUT_W'(ibw_pkg::OUT_MAX);
		end else if (x < ibw_pkg::OUT_MIN) begin
			r = ibw_pkg::OUT_W'(ibw_pkg::OUT_MIN);
		end else begin
			r = ibw_pkg::OUT_W'(x);
		end
		return r;
	endfunction

	// every cycle takes an item
	assign busy = 1'b0;

	// ------------------------------------------------------------------ s1
	// edge vectors e = tr - tl, f = bl - tl, g = tl - tr + br - bl, h = p - tl
	logic signed [VW-1:0] px, py;
	logic                 v_s1;
	logic signed [VW-1:0] ex_s1, ey_s1, fx_s1, fy_s1, gx_s1, gy_s1, hx_s1, hy_s1;

	assign px = signed'(VW'(point_x) << COORD_FRAC_BITS);
	assign py = signed'(VW'(point_y) << COORD_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		ex_s1 <= VW'(top_right_x) - VW'(top_left_x);
		ey_s1 <= VW'(top_right_y) - VW'(top_left_y);
		fx_s1 <= VW'(bottom_left_x) - VW'(top_left_x);
		fy_s1 <= VW'(bottom_left_y) - VW'(top_left_y);
		gx_s1 <= VW'(top_left_x) - VW'(top_right_x) + VW'(bottom_right_x) - VW'(bottom_left_x);
		gy_s1 <= VW'(top_left_y) - VW'(top_right_y) + VW'(bottom_right_y) - VW'(bottom_left_y);
		hx_s1 <= px - VW'(top_left_x);
		hy_s1 <= py - VW'(top_left_y);
	end

	// ------------------------------------------------------------------ s2
	// degenerate test and the cross product terms
	logic                   degen;
	ibw_pkg::ibw_flags_t    fl_s2;
	logic signed [2*VW-1:0] gf_a_s2, gf_b_s2, ef_a_s2, ef_b_s2;
	logic signed [2*VW-1:0] hg_a_s2, hg_b_s2, he_a_s2, he_b_s2;
	logic signed [VW-1:0]   hx_s2, ex_s2, fx_s2, gx_s2;

	assign degen = (ex_s1 == fx_s1 && ey_s1 == fy_s1) || (ex_s1 == gx_s1 && ey_s1 == gy_s1) ||
		(ex_s1 == hx_s1 && ey_s1 == hy_s1) || (fx_s1 == gx_s1 && fy_s1 == gy_s1) ||
		(fx_s1 == hx_s1 && fy_s1 == hy_s1) || (gx_s1 == hx_s1 && gy_s1 == hy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s2 <= '0;
		end else begin
			fl_s2 <= '{vld: v_s1, degen: degen, lin: 1'b0, neg: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		gf_a_s2 <= gx_s1 * fy_s1;
		gf_b_s2 <= gy_s1 * fx_s1;
		ef_a_s2 <= ex_s1 * fy_s1;
		ef_b_s2 <= ey_s1 * fx_s1;
		hg_a_s2 <= hx_s1 * gy_s1;
		hg_b_s2 <= hy_s1 * gx_s1;
		he_a_s2 <= hx_s1 * ey_s1;
		he_b_s2 <= hy_s1 * ex_s1;
		hx_s2   <= hx_s1;
		ex_s2   <= ex_s1;
		fx_s2   <= fx_s1;
		gx_s2   <= gx_s1;
	end

	// ------------------------------------------------------------------ s3
	// quadratic coefficients k2 = g x f, k1 = e x f + h x g, k0 = h x e
	ibw_pkg::ibw_flags_t fl_s3;
	sb_t                 sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s3 <= '0;
		end else begin
			fl_s3 <= fl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sb_s3.k2 <= KW'(gf_a_s2) - KW'(gf_b_s2);
		sb_s3.k1 <= (KW'(ef_a_s2) - KW'(ef_b_s2)) + (KW'(hg_a_s2) - KW'(hg_b_s2));
		sb_s3.k0 <= KW'(he_a_s2) - KW'(he_b_s2);
		sb_s3.hx <= hx_s2;
		sb_s3.ex <= ex_s2;
		sb_s3.fx <= fx_s2;
		sb_s3.gx <= gx_s2;
	end

	// ------------------------------------------------------------------ s4
	// linear test on |k2|, partial products of k1*k1 and k0*k2
	logic [KW-1:0]          k2_mag;
	logic signed [LK:0]     k1_lo, k0_lo, k2_lo;
	logic signed [KW-LK-1:0] k1_hi, k0_hi, k2_hi;
	ibw_pkg::ibw_flags_t    fl_s4;
	sb_t                    sb_s4;
	logic signed [2*(KW-LK)-1:0] a_hh_s4, b_hh_s4;
	logic signed [KW:0]          a_hl_s4, b_hl_s4, b_lh_s4;
	logic signed [2*LK+1:0]      a_ll_s4, b_ll_s4;

	assign k2_mag = sb_s3.k2[KW-1] ? KW'(-sb_s3.k2) : KW'(sb_s3.k2);
	assign k1_lo  = $signed({1'b0, sb_s3.k1[LK-1:0]});
	assign k0_lo  = $signed({1'b0, sb_s3.k0[LK-1:0]});
	assign k2_lo  = $signed({1'b0, sb_s3.k2[LK-1:0]});
	assign k1_hi  = $signed(sb_s3.k1[KW-1:LK]);
	assign k0_hi  = $signed(sb_s3.k0[KW-1:LK]);
	assign k2_hi  = $signed(sb_s3.k2[KW-1:LK]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s4 <= '0;
		end else begin
			fl_s4 <= '{vld: fl_s3.vld, degen: fl_s3.degen,
				lin: k2_mag < KW'(LIN_LIM), neg: fl_s3.neg};
		end
	end

	always_ff @(posedge clk) begin
		sb_s4   <= sb_s3;
		a_hh_s4 <= k1_hi * k1_hi;
		a_hl_s4 <= k1_hi * k1_lo;
		a_ll_s4 <= k1_lo * k1_lo;
		b_hh_s4 <= k0_hi * k2_hi;
		b_hl_s4 <= k0_hi * k2_lo;
		b_lh_s4 <= k0_lo * k2_hi;
		b_ll_s4 <= k0_lo * k2_lo;
	end

	// ------------------------------------------------------------------ s5
	// recombine k1^2 and k0*k2
	ibw_pkg::ibw_flags_t  fl_s5;
	sb_t                  sb_s5;
	logic signed [DW-1:0] sq_s5, pr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s5 <= '0;
		end else begin
			fl_s5 <= fl_s4;
		end
	end

	always_ff @(posedge clk) begin
		sb_s5 <= sb_s4;
		sq_s5 <= (DW'(a_hh_s4) <<< (2 * LK)) + (DW'(a_hl_s4) <<< (LK + 1)) + DW'(a_ll_s4);
		pr_s5 <= (DW'(b_hh_s4) <<< (2 * LK)) + ((DW'(b_hl_s4) + DW'(b_lh_s4)) <<< LK) +
			DW'(b_ll_s4);
	end

	// ------------------------------------------------------------------ s6
	// discriminant k1^2 - 4*k0*k2 loads the root pipeline
	logic signed [DW-1:0] disc;
	ibw_pkg::ibw_flags_t  fl_rt_s [SW+1];
	sb_t                  sb_rt_s [SW+1];
	logic [RW-1:0]        rem_rt_s [SW+1];
	logic [SW-1:0]        root_rt_s [SW+1];
	logic [XW-1:0]        x_rt_s [SW+1];

	assign disc = sq_s5 - (pr_s5 <<< 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_rt_s[0] <= '0;
		end else begin
			fl_rt_s[0] <= '{vld: fl_s5.vld, degen: fl_s5.degen, lin: fl_s5.lin,
				neg: disc[DW-1]};
		end
	end

	always_ff @(posedge clk) begin
		sb_rt_s[0]   <= sb_s5;
		rem_rt_s[0]  <= '0;
		root_rt_s[0] <= '0;
		// negative discriminant feeds zero, the root is unused then
		x_rt_s[0]    <= disc[DW-1] ? '0 : disc[XW-1:0];
	end

	// ------------------------------------------------------------------ root
	// restoring square root, one root bit per stage
	for (genvar j = 0; j < SW; j++) begin : g_sqrt
		logic [RW+1:0] rn;
		logic [RW+1:0] tr;
		logic          ge;

		assign rn = {rem_rt_s[j], x_rt_s[j][XW-1 -: 2]};
		assign tr = (RW+2)'({root_rt_s[j], 2'b01});
		assign ge = rn >= tr;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fl_rt_s[j+1] <= '0;
			end else begin
				fl_rt_s[j+1] <= fl_rt_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sb_rt_s[j+1]   <= sb_rt_s[j];
			rem_rt_s[j+1]  <= ge ? RW'(rn - tr) : RW'(rn);
			root_rt_s[j+1] <= {root_rt_s[j][SW-2:0], ge};
			x_rt_s[j+1]    <= x_rt_s[j] << 2;
		end
	end

	// ------------------------------------------------------------------ s7
	// round the root to nearest
	ibw_pkg::ibw_flags_t fl_s7;
	sb_t                 sb_s7;
	logic [SW:0]         s_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s7 <= '0;
		end else begin
			fl_s7 <= fl_rt_s[SW];
		end
	end

	always_ff @(posedge clk) begin
		sb_s7 <= sb_rt_s[SW];
		s_s7  <= (SW+1)'(root_rt_s[SW]) + (SW+1)'(rem_rt_s[SW] > RW'(root_rt_s[SW]));
	end

	// ------------------------------------------------------------------ s8
	// common form v = b / a, u = (hx*a - fx*b) / (ex*a + gx*b)
	// linear: a = k1, b = -k0; quadratic: a = 2*k2, b = -k1 -/+ s
	logic signed [NW-1:0] s_sg;
	ibw_pkg::ibw_flags_t  fl_s8;
	logic signed [NW-1:0] a_s8, b1_s8, b2_s8;
	logic signed [VW-1:0] hx_s8, ex_s8, fx_s8, gx_s8;

	assign s_sg = NW'($signed({1'b0, s_s7}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s8 <= '0;
		end else begin
			fl_s8 <= fl_s7;
		end
	end

	always_ff @(posedge clk) begin
		a_s8  <= fl_s7.lin ? NW'(sb_s7.k1) : (NW'(sb_s7.k2) <<< 1);
		b1_s8 <= fl_s7.lin ? -NW'(sb_s7.k0) : (-NW'(sb_s7.k1) - s_sg);
		b2_s8 <= -NW'(sb_s7.k1) + s_sg;
		hx_s8 <= sb_s7.hx;
		ex_s8 <= sb_s7.ex;
		fx_s8 <= sb_s7.fx;
		gx_s8 <= sb_s7.gx;
	end

	// ------------------------------------------------------------------ s9
	// split products, a and b cut into a low and a high slice
	logic signed [LN:0]      a_lo, b1_lo, b2_lo;
	logic signed [NW-LN-1:0] a_hi, b1_hi, b2_hi;
	ibw_pkg::ibw_flags_t     fl_s9;
	logic signed [NW-1:0]    a_s9, b1_s9, b2_s9;
	logic signed [VW+LN:0]   hal_s9, eal_s9, fb1l_s9, gb1l_s9, fb2l_s9, gb2l_s9;
	logic signed [VW+NW-LN-1:0] hah_s9, eah_s9, fb1h_s9, gb1h_s9, fb2h_s9, gb2h_s9;

	assign a_lo  = $signed({1'b0, a_s8[LN-1:0]});
	assign b1_lo = $signed({1'b0, b1_s8[LN-1:0]});
	assign b2_lo = $signed({1'b0, b2_s8[LN-1:0]});
	assign a_hi  = $signed(a_s8[NW-1:LN]);
	assign b1_hi = $signed(b1_s8[NW-1:LN]);
	assign b2_hi = $signed(b2_s8[NW-1:LN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s9 <= '0;
		end else begin
			fl_s9 <= fl_s8;
		end
	end

	always_ff @(posedge clk) begin
		a_s9    <= a_s8;
		b1_s9   <= b1_s8;
		b2_s9   <= b2_s8;
		hal_s9  <= hx_s8 * a_lo;
		hah_s9  <= hx_s8 * a_hi;
		eal_s9  <= ex_s8 * a_lo;
		eah_s9  <= ex_s8 * a_hi;
		fb1l_s9 <= fx_s8 * b1_lo;
		fb1h_s9 <= fx_s8 * b1_hi;
		gb1l_s9 <= gx_s8 * b1_lo;
		gb1h_s9 <= gx_s8 * b1_hi;
		fb2l_s9 <= fx_s8 * b2_lo;
		fb2h_s9 <= fx_s8 * b2_hi;
		gb2l_s9 <= gx_s8 * b2_lo;
		gb2h_s9 <= gx_s8 * b2_hi;
	end

	// ------------------------------------------------------------------ s10
	ibw_pkg::ibw_flags_t  fl_s10;
	logic signed [NW-1:0] a_s10, b1_s10, b2_s10;
	logic signed [PW-1:0] ha_s10, ea_s10, fb1_s10, gb1_s10, fb2_s10, gb2_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s10 <= '0;
		end else begin
			fl_s10 <= fl_s9;
		end
	end

	always_ff @(posedge clk) begin
		a_s10   <= a_s9;
		b1_s10  <= b1_s9;
		b2_s10  <= b2_s9;
		ha_s10  <= (PW'(hah_s9) <<< LN) + PW'(hal_s9);
		ea_s10  <= (PW'(eah_s9) <<< LN) + PW'(eal_s9);
		fb1_s10 <= (PW'(fb1h_s9) <<< LN) + PW'(fb1l_s9);
		gb1_s10 <= (PW'(gb1h_s9) <<< LN) + PW'(gb1l_s9);
		fb2_s10 <= (PW'(fb2h_s9) <<< LN) + PW'(fb2l_s9);
		gb2_s10 <= (PW'(gb2h_s9) <<< LN) + PW'(gb2l_s9);
	end

	// ------------------------------------------------------------------ s11
	// divider operands for both roots
	ibw_pkg::ibw_flags_t  fl_s11;
	logic signed [NW-1:0] a_s11, b1_s11, b2_s11;
	logic signed [PW-1:0] nu1_s11, du1_s11, nu2_s11, du2_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_s11 <= '0;
		end else begin
			fl_s11 <= fl_s10;
		end
	end

	always_ff @(posedge clk) begin
		a_s11   <= a_s10;
		b1_s11  <= b1_s10;
		b2_s11  <= b2_s10;
		nu1_s11 <= ha_s10 - fb1_s10;
		du1_s11 <= ea_s10 + gb1_s10;
		nu2_s11 <= ha_s10 - fb2_s10;
		du2_s11 <= ea_s10 + gb2_s10;
	end

	// ------------------------------------------------------------------ divide
	// four dividers in parallel, flags follow in a matching delay line
	logic signed [QW+1:0] v1, u1, v2, u2;
	ibw_pkg::ibw_flags_t  fl_dv_s [QW+2];

	ibw_div #(.NIW(NW), .DIW(NW), .QW(QW), .FB(WEIGHT_FRAC_BITS)) u_div_v1 (
		.clk (clk), .n (b1_s11), .d (a_s11), .q (v1)
	);
	ibw_div #(.NIW(PW), .DIW(PW), .QW(QW), .FB(WEIGHT_FRAC_BITS)) u_div_u1 (
		.clk (clk), .n (nu1_s11), .d (du1_s11), .q (u1)
	);
	ibw_div #(.NIW(NW), .DIW(NW), .QW(QW), .FB(WEIGHT_FRAC_BITS)) u_div_v2 (
		.clk (clk), .n (b2_s11), .d (a_s11), .q (v2)
	);
	ibw_div #(.NIW(PW), .DIW(PW), .QW(QW), .FB(WEIGHT_FRAC_BITS)) u_div_u2 (
		.clk (clk), .n (nu2_s11), .d (du2_s11), .q (u2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_dv_s[0] <= '0;
		end else begin
			fl_dv_s[0] <= fl_s11;
		end
	end

	for (genvar k = 1; k < QW + 2; k++) begin : g_fdly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fl_dv_s[k] <= '0;
			end else begin
				fl_dv_s[k] <= fl_dv_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------ output
	// degen, neg: fixed; lin: root 1; else root 1 if u, v in [0, 1], else root 2
	ibw_pkg::ibw_flags_t  fl_o;
	logic                 in1;
	logic signed [QW+1:0] u_sel, v_sel;
	logic                 ok_sel;

	assign fl_o = fl_dv_s[QW+1];
	assign in1  = !(u1 < 0 || u1 > ONE_Q || v1 < 0 || v1 > ONE_Q);

	always_comb begin
		priority if (fl_o.degen) begin
			u_sel  = ONE_Q;
			v_sel  = '0;
			ok_sel = 1'b0;
		end else if (fl_o.lin) begin
			u_sel  = u1;
			v_sel  = v1;
			ok_sel = 1'b1;
		end else if (fl_o.neg) begin
			u_sel  = -ONE_Q;
			v_sel  = -ONE_Q;
			ok_sel = 1'b0;
		end else if (in1) begin
			u_sel  = u1;
			v_sel  = v1;
			ok_sel = 1'b1;
		end else begin
			u_sel  = u2;
			v_sel  = v2;
			ok_sel = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fl_o.vld;
		end
	end

	always_ff @(posedge clk) begin
		weight_u       <= sat_w(u_sel);
		weight_v       <= sat_w(v_sel);
		solution_valid <= ok_sel;
	end

endmodule

// ===== hdl/ibw_chk.sv =====
// ----------------------------------------------------------------------------
// ibw_chk
// port level checks of the inverse bilinear weights core
// ----------------------------------------------------------------------------
module ibw_chk #(
	parameter int WEIGHT_FRAC_BITS = 16,
	parameter int LAT              = 83
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic signed [ibw_pkg::OUT_W-1:0] weight_u,
	input logic signed [ibw_pkg::OUT_W-1:0] weight_v,
	input logic                             solution_valid
);

	localparam int ONE     = 1 << WEIGHT_FRAC_BITS;
	localparam int ONE_SAT = (ONE > ibw_pkg::OUT_MAX) ? ibw_pkg::OUT_MAX : ONE;
	localparam int NEG_SAT = (-ONE < ibw_pkg::OUT_MIN) ? ibw_pkg::OUT_MIN : -ONE;

	// every accepted item gives its result a fixed time later
	a_lat : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("item result missing at fixed latency");

	// no result without an item accepted at the matching time
	a_src : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted item");

	// an unsolved item carries one of the two fixed answers
	a_inv : assert property (@(posedge clk) disable iff (!arst_n)
		done && !solution_valid |->
		(weight_u == ONE_SAT && weight_v == 0) || (weight_u == NEG_SAT && weight_v == NEG_SAT))
		else $error("unsolved item with unexpected weights");

endmodule

bind inverse_bilinear_weights_core ibw_chk #(
	.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
	.LAT              (LATENCY)
) u_ibw_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.weight_u       (weight_u),
	.weight_v       (weight_v),
	.solution_valid (solution_valid)
);
